FILE: rtl/core/sr_stat_pkg.sv
// Package for the per-user scheduling request statistics table.
// Holds request/report types, table entry type, FSM states and control bundles.
// No dependencies.
`default_nettype none

package sr_stat_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned MEAN_W  = 15;
  localparam int unsigned RESID_W = 4;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned PROD_W  = SUM_W + 7;

  localparam logic [CNT_W-1:0]   COUNT_MAX   = '1;
  localparam logic [CNT_W-1:0]   REPORT_STEP = 32'd10;
  localparam logic [6:0]         SCALE       = 7'd100;
  localparam logic [RESID_W-1:0] RESID_LAST  = 4'd9;
  // Quotient never exceeds 25500, so 15 restoring steps cover it.
  localparam logic [STEP_W-1:0]  DIV_LAST    = 4'd14;

  typedef struct packed {
    logic [15:0] user_id;
    logic [9:0]  frame_number;
    logic [7:0]  slot_number;
    logic [7:0]  link_quality;
    logic [63:0] time_stamp;
  } req_t;

  typedef struct packed {
    logic [63:0]       time_stamp_out;
    logic [15:0]       user_id_out;
    logic [9:0]        frame_out;
    logic [7:0]        slot_out;
    logic [7:0]        quality_out;
    logic [CNT_W-1:0]  request_count;
    logic [MEAN_W-1:0] mean_quality_x100;
  } rpt_t;

  // One table row; resid tracks count modulo ten.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CNT_W-1:0]   count;
    logic [SUM_W-1:0]   sum;
    logic [RESID_W-1:0] resid;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MISS,
    ST_HIT,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic rd;
    logic next_addr;
    logic ins;
    logic upd;
    logic mul_load;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic key_match;
    logic last_entry;
    logic report;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/sr_stat_ctrl.sv
// Controller FSM for the scheduling request statistics table.
// Sequences scan, insert/update, divide and report. Depends on sr_stat_pkg.
`default_nettype none

module sr_stat_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  sr_stat_pkg::status_t status_i,
  output sr_stat_pkg::cmd_t    cmd_o
);
  import sr_stat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.fill_zero ? ST_MISS : ST_READ;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (status_i.key_match) begin
          state_d = ST_HIT;
        end else if (status_i.last_entry) begin
          state_d = ST_MISS;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_MISS: state_d = ST_EMIT;
      ST_HIT:  state_d = status_i.report ? ST_MUL : ST_IDLE;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_READ: cmd_o.rd = 1'b1;
      ST_CMP:  cmd_o.next_addr = !status_i.key_match && !status_i.last_entry;
      ST_MISS: cmd_o.ins = 1'b1;
      ST_HIT:  cmd_o.upd = 1'b1;
      ST_MUL:  cmd_o.mul_load = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_EMIT: cmd_o.emit = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/sr_stat_dp.sv
// Datapath for the scheduling request statistics table: entry memory,
// fill count, scan address, iterative divider and report register.
// Depends on sr_stat_pkg.
`default_nettype none

module sr_stat_dp #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  sr_stat_pkg::req_t    in_i,
  input  sr_stat_pkg::cmd_t    cmd_i,
  output sr_stat_pkg::status_t status_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output sr_stat_pkg::rpt_t    out_o
);
  import sr_stat_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(TABLE_ENTRIES);

  entry_t mem [TABLE_ENTRIES];

  req_t              req_q;
  entry_t            rd_q;
  logic [AW-1:0]     addr_q;
  logic [CW-1:0]     fill_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  rem_q;
  logic [MEAN_W-1:0] quo_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  rpt_t              out_q;

  logic              full;
  logic              saturated;
  entry_t            upd_entry;
  entry_t            new_entry;
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic [PROD_W-1:0] prod;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic              out_free;

  assign full      = (fill_q == FILL_MAX);
  assign saturated = (rd_q.count == COUNT_MAX);

  // Hold count and sum once the count saturates.
  always_comb begin
    upd_entry = rd_q;
    if (!saturated) begin
      upd_entry.count = rd_q.count + CNT_W'(1);
      upd_entry.sum   = rd_q.sum + SUM_W'(req_q.link_quality);
      upd_entry.resid = (rd_q.resid == RESID_LAST) ? '0 : rd_q.resid + RESID_W'(1);
    end
  end

  always_comb begin
    new_entry.key   = req_q.user_id;
    new_entry.count = CNT_W'(1);
    new_entry.sum   = SUM_W'(req_q.link_quality);
    new_entry.resid = RESID_W'(1);
  end

  assign we    = cmd_i.upd || (cmd_i.ins && !full);
  assign waddr = cmd_i.upd ? addr_q : fill_q[AW-1:0];
  assign wdata = cmd_i.upd ? upd_entry : new_entry;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[addr_q];
    end
  end

  assign prod  = PROD_W'(sum_q) * PROD_W'(SCALE);
  assign trial = {rem_q, quo_q[MEAN_W-1]};
  assign ge    = (trial >= {1'b0, cnt_q});

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      addr_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ins && !full) begin
        fill_q <= fill_q + CW'(1);
      end
      if (cmd_i.capture) begin
        addr_q <= '0;
      end else if (cmd_i.next_addr) begin
        addr_q <= addr_q + AW'(1);
      end
      if (cmd_i.mul_load) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_i;
    end
    if (cmd_i.ins) begin
      cnt_q <= CNT_W'(1);
      quo_q <= MEAN_W'(req_q.link_quality) * MEAN_W'(SCALE);
    end else if (cmd_i.upd) begin
      cnt_q <= upd_entry.count;
      sum_q <= upd_entry.sum;
    end else if (cmd_i.mul_load) begin
      rem_q <= prod[PROD_W-1:MEAN_W];
      quo_q <= prod[MEAN_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
      quo_q <= {quo_q[MEAN_W-2:0], ge};
    end
    if (cmd_i.emit) begin
      out_q.time_stamp_out    <= req_q.time_stamp;
      out_q.user_id_out       <= req_q.user_id;
      out_q.frame_out         <= req_q.frame_number;
      out_q.slot_out          <= req_q.slot_number;
      out_q.quality_out       <= req_q.link_quality;
      out_q.request_count     <= cnt_q;
      out_q.mean_quality_x100 <= quo_q;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o.fill_zero  = (fill_q == '0);
    status_o.key_match  = (rd_q.key == req_q.user_id);
    status_o.last_entry = ((CW'(addr_q) + CW'(1)) == fill_q);
    status_o.report     = (upd_entry.count <= REPORT_STEP) || (upd_entry.resid == '0);
    status_o.div_done   = (step_q == DIV_LAST);
    status_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/per_ue_sr_statistics_table.sv
// Per-user scheduling request statistics table, top level (sr_stat_ctrl, sr_stat_dp).
// A new user is scanned past every stored entry (read, compare), inserted if there is
// room and reported; a known user is scanned up to its entry, updated and, if due,
// reported after the 15-step divider. One request at a time, the next taken the cycle
// after the report loads, or after an update with no report; the scan bounds the rate.
// Reset empties the table at once by clearing the fill count; no clearing pass.
`default_nettype none

module per_ue_sr_statistics_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  sr_stat_pkg::req_t  in_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output sr_stat_pkg::rpt_t  out_o
);
  import sr_stat_pkg::*;

  // Entries fill from index 0 upward and are never released, so the valid
  // entries are always a prefix of the table: a fill count stands in for
  // per-entry valid bits. A lookup scans that prefix in order, one memory
  // read per entry, and takes the first key match.
  //
  // On a match the count and quality sum are bumped (frozen at count
  // saturation) and written back. A count-modulo-ten residue rides in each
  // entry so the report rule needs no divider. When a report is due, the
  // sum is scaled by 100 and divided by the count in a restoring divider,
  // one quotient bit per cycle.
  //
  // The report register decouples the output: a new request is taken while
  // the previous report still waits downstream.

  cmd_t    cmd;
  status_t status;

  sr_stat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sr_stat_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // Drop input acceptance right after a request is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  // Mean of 8-bit qualities times 100 never exceeds 25500.
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.mean_quality_x100 <= 15'd25500)
    else $error("mean quality out of range");

  // Reported count is never zero.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.request_count != '0)
    else $error("zero request count reported");

endmodule

`default_nettype wire
